// File: hdl/text_console_cursor_engine_defines.svh
// assertion helpers for the text console cursor engine
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TCCE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TCCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tcce_pkg.sv
package tcce_pkg;

    // field widths
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // item kinds
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } tcce_op_t;

    // configuration register indexes
    localparam logic [1:0] REG_TEXT_ATTR = 2'd0;
    localparam logic [1:0] REG_LAST_ROW  = 2'd1;
    localparam logic [1:0] REG_LAST_COL  = 2'd2;

    // register reset values
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RST = 8'd7;
    localparam logic [ROW_W-1:0]  LAST_ROW_RST  = 5'd24;
    localparam logic [COL_W-1:0]  LAST_COL_RST  = 7'd79;

    // control characters
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

endpackage

// File: hdl/text_console_cursor_engine.sv
// Text console cursor engine: a character-cell screen store plus a cursor.
// Input channel s_*: one item per write-char, read-cell or clear-screen op;
// the op kind is in s_tuser, last_of_write travels on s_tlast.
// Result channel m_*: exactly one item per input item, carrying read data,
// the cursor after the op, a scroll flag and write_done on m_tlast.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data write text_attr, last_row
// and last_col; write them only while the block is idle.
// Steps per item, all through the one screen memory:
//   plain char, backspace, newline without scroll: EXEC moves the cursor
//     and writes the cell, if any; read cell: EXEC issues a registered
//     memory read and RD_WAIT takes the data, skipped when out of range
//   scroll: one read (SCR_RD) and one write one row up (SCR_WR) per moved
//     cell, then SCR_BLANK blanks the bottom row
//   clear screen: CLR writes every cell, one cell written per cycle
// m_tvalid rises in the cycle s_tready returns.
// After reset all ROWS*COLS cells (2000 at the defaults) are zeroed while
// s_tready stays low; config writes are still taken.
// A finished result sits in the output register; the next item is accepted
// while it waits, but a second result holds the engine until m_tready.
`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_row[12:8], cell_col[19:13]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    input  logic        s_tlast,   // last_of_write
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[15:0], cursor_row[20:16],
                                   // cursor_col[27:21], scrolled[28]
    output logic        m_tlast,   // write_done
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data
);

    localparam int CELLS  = ROWS * COLS;
    localparam int AddrW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MaxRow = (ROWS - 1 > 31) ? 31 : ROWS - 1;
    localparam int MaxCol = (COLS - 1 > 127) ? 127 : COLS - 1;
    localparam logic [ROW_W-1:0] MAX_ROW   = ROW_W'(MaxRow);
    localparam logic [COL_W-1:0] MAX_COL   = COL_W'(MaxCol);
    localparam logic [AddrW-1:0] LAST_CELL = AddrW'(CELLS - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_EXEC, S_RD_WAIT, S_SCR_RD, S_SCR_WR,
        S_SCR_BLANK, S_CLR, S_DONE
    } state_t;

    function automatic logic [AddrW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        cell_addr = AddrW'(int'(r) * COLS + int'(c));
    endfunction

    state_t state_reg;

    // configuration registers
    logic [ATTR_W-1:0] text_attr_reg;
    logic [ROW_W-1:0]  last_row_reg;
    logic [COL_W-1:0]  last_col_reg;

    // cursor and sequencer state
    logic [ROW_W-1:0]  cursor_row_reg;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [ROW_W-1:0]  scr_row_reg;
    logic [COL_W-1:0]  scr_col_reg;
    logic [AddrW-1:0]  sweep_idx_reg;
    logic              clr_blank_reg;

    // latched input item
    tcce_op_t          op_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ROW_W-1:0]  rd_row_reg;
    logic [COL_W-1:0]  rd_col_reg;
    logic              last_reg;

    // pending result
    logic [CELL_W-1:0] res_data_reg;
    logic              res_scrolled_reg;
    logic              res_done_reg;

    // output register
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_last_reg;

    // screen memory
    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AddrW-1:0]  mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AddrW-1:0]  mem_raddr;

    // working values
    logic [ROW_W-1:0]  eff_lr;
    logic [COL_W-1:0]  eff_lc;
    logic [ROW_W-1:0]  cr;
    logic [COL_W-1:0]  cc;
    logic [ROW_W-1:0]  bs_row;
    logic [COL_W-1:0]  bs_col;
    logic [CELL_W-1:0] blank;
    logic              is_nl;
    logic              is_bs;
    logic              rd_in_range;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // area in use, clamped cursor and backspace target
    always_comb begin
        eff_lr      = (last_row_reg > MAX_ROW) ? MAX_ROW : last_row_reg;
        eff_lc      = (last_col_reg > MAX_COL) ? MAX_COL : last_col_reg;
        cr          = (cursor_row_reg > eff_lr) ? eff_lr : cursor_row_reg;
        cc          = (cursor_col_reg > eff_lc) ? eff_lc : cursor_col_reg;
        blank       = {text_attr_reg, CHAR_SPACE};
        is_nl       = (char_reg == CHAR_NEWLINE);
        is_bs       = (char_reg == CHAR_BACKSPACE);
        rd_in_range = (int'(rd_row_reg) < ROWS) && (int'(rd_col_reg) < COLS);
        bs_row      = cr;
        bs_col      = cc;
        if (cc != '0) begin
            bs_col = cc - COL_W'(1);
        end else if (cr != '0) begin
            bs_row = cr - ROW_W'(1);
            bs_col = eff_lc;
        end
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (state_reg)
            S_INIT, S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_idx_reg;
                mem_wdata = clr_blank_reg ? blank : '0;
            end
            S_EXEC: begin
                if (op_reg == OP_WRITE && !is_nl) begin
                    mem_we    = 1'b1;
                    mem_waddr = is_bs ? cell_addr(bs_row, bs_col) : cell_addr(cr, cc);
                    mem_wdata = is_bs ? blank : {text_attr_reg, char_reg};
                end
                if (op_reg == OP_READ && rd_in_range) begin
                    mem_re    = 1'b1;
                    mem_raddr = cell_addr(rd_row_reg, rd_col_reg);
                end
            end
            S_SCR_RD: begin
                if (scr_row_reg != eff_lr) begin
                    mem_re    = 1'b1;
                    mem_raddr = cell_addr(scr_row_reg + ROW_W'(1), scr_col_reg);
                end
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(scr_row_reg, scr_col_reg);
                mem_wdata = rd_data_reg;
            end
            S_SCR_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(scr_row_reg, scr_col_reg);
                mem_wdata = blank;
            end
            S_IDLE, S_RD_WAIT, S_DONE: begin
            end
        endcase
    end

    // screen memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg <= TEXT_ATTR_RST;
            last_row_reg  <= LAST_ROW_RST;
            last_col_reg  <= LAST_COL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TEXT_ATTR: text_attr_reg <= cfg_wr_data;
                REG_LAST_ROW:  last_row_reg  <= cfg_wr_data[ROW_W-1:0];
                REG_LAST_COL:  last_col_reg  <= cfg_wr_data[COL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer, cursor and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            sweep_idx_reg  <= '0;
            clr_blank_reg  <= 1'b0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // drop a taken result unless a new one is loaded below
            if (m_valid_reg && m_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                // zero the store after reset
                S_INIT: begin
                    sweep_idx_reg <= sweep_idx_reg + AddrW'(1);
                    if (sweep_idx_reg == LAST_CELL) begin
                        state_reg <= S_IDLE;
                    end
                end
                // take an item
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= tcce_op_t'(s_tuser);
                        char_reg   <= s_tdata[7:0];
                        rd_row_reg <= s_tdata[12:8];
                        rd_col_reg <= s_tdata[19:13];
                        last_reg   <= s_tlast;
                        state_reg  <= S_EXEC;
                    end
                end
                // decode and do the single-cell part
                S_EXEC: begin
                    res_data_reg     <= '0;
                    res_scrolled_reg <= 1'b0;
                    res_done_reg     <= 1'b0;
                    state_reg        <= S_DONE;
                    unique case (op_reg)
                        OP_WRITE: begin
                            res_done_reg <= last_reg;
                            if (is_nl || (!is_bs && cc == eff_lc)) begin
                                cursor_col_reg <= '0;
                                if (cr == eff_lr) begin
                                    cursor_row_reg   <= cr;
                                    res_scrolled_reg <= 1'b1;
                                    scr_row_reg      <= '0;
                                    scr_col_reg      <= '0;
                                    state_reg        <= S_SCR_RD;
                                end else begin
                                    cursor_row_reg <= cr + ROW_W'(1);
                                end
                            end else if (is_bs) begin
                                cursor_row_reg <= bs_row;
                                cursor_col_reg <= bs_col;
                            end else begin
                                cursor_row_reg <= cr;
                                cursor_col_reg <= cc + COL_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (rd_in_range) begin
                                state_reg <= S_RD_WAIT;
                            end
                        end
                        OP_CLEAR: begin
                            sweep_idx_reg <= '0;
                            clr_blank_reg <= 1'b1;
                            state_reg     <= S_CLR;
                        end
                        OP_NONE: begin
                        end
                    endcase
                end
                S_RD_WAIT: begin
                    res_data_reg <= rd_data_reg;
                    state_reg    <= S_DONE;
                end
                // scroll: read the cell below
                S_SCR_RD: begin
                    if (scr_row_reg == eff_lr) begin
                        scr_col_reg <= '0;
                        state_reg   <= S_SCR_BLANK;
                    end else begin
                        state_reg <= S_SCR_WR;
                    end
                end
                // scroll: write it one row up
                S_SCR_WR: begin
                    if (scr_col_reg == eff_lc) begin
                        scr_col_reg <= '0;
                        scr_row_reg <= scr_row_reg + ROW_W'(1);
                    end else begin
                        scr_col_reg <= scr_col_reg + COL_W'(1);
                    end
                    state_reg <= S_SCR_RD;
                end
                // scroll: blank the bottom row
                S_SCR_BLANK: begin
                    if (scr_col_reg == eff_lc) begin
                        state_reg <= S_DONE;
                    end else begin
                        scr_col_reg <= scr_col_reg + COL_W'(1);
                    end
                end
                // clear screen sweep
                S_CLR: begin
                    sweep_idx_reg <= sweep_idx_reg + AddrW'(1);
                    if (sweep_idx_reg == LAST_CELL) begin
                        state_reg <= S_DONE;
                    end
                end
                // hand the result to the output register
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000, res_scrolled_reg, cursor_col_reg,
                                        cursor_row_reg, res_data_reg};
                        m_last_reg  <= res_done_reg;
                        state_reg   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // checks
    `TCCE_ASSERT_NOW(a_wr_in_range, aclk, aresetn, mem_we, int'(mem_waddr) < CELLS, "screen write out of range")
    `TCCE_ASSERT_NOW(a_scroll_col0, aclk, aresetn, m_valid_reg && m_data_reg[28], m_data_reg[27:21] == '0, "scroll without column zero")
    `TCCE_ASSERT_NOW(a_done_no_data, aclk, aresetn, m_valid_reg && m_last_reg, m_data_reg[15:0] == '0, "write result carries read data")
    `TCCE_ASSERT_NEXT(a_exec_after_accept, aclk, aresetn, s_tvalid && s_tready, state_reg == S_EXEC, "accepted item not decoded")

endmodule
